// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;

	localparam int COMP_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_W      = 32;
	localparam int REG_W      = 64;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = $clog2(NUM_REGS);
	localparam int QUO_W      = COMP_WIDTH + FRAC_BITS;
	localparam int DIV_STEPS  = QUO_W;
	localparam int SUM_W      = 2 * COMP_WIDTH + 3;

	localparam logic [REG_W-1:0] FIX_ONE = REG_W'(1) << FRAC_BITS;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;

	localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
		FIX_ONE, '0, FIX_ONE << 32, '0, '0, FIX_ONE, '0, FIX_ONE << 32
	};

	typedef struct packed {
		logic                         valid;
		logic                         divide;
		logic                         wzero;
		logic                         ovf;
		logic [2:0]                   neg;
		logic [3:0][COMP_WIDTH-1:0]   res;
	} side_t;

endpackage

// ===== rtl/core/vtp_lane.sv =====
module vtp_lane
	import vtp_pkg::*;
(
	input  logic  clk,
	input  comp_t coef [4],
	input  comp_t vec [4],
	output comp_t res,
	output logic  ovf
);

	logic signed [2*COMP_WIDTH-1:0] prod_s1 [4];
	logic signed [SUM_W-1:0]        sum;
	logic signed [SUM_W-1:0]        rnd;
	logic [SUM_W-FRAC_BITS-COMP_WIDTH:0] hi;
	logic                           sat;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			prod_s1[c] <= coef[c] * vec[c];
		end
	end

	// exact sum, then round half towards plus infinity
	always_comb begin
		sum = SUM_W'(FIX_ONE >> 1);
		for (int c = 0; c < 4; c++) begin
			sum = sum + SUM_W'(prod_s1[c]);
		end
		rnd = sum >>> FRAC_BITS;
		hi  = rnd[SUM_W-FRAC_BITS-1:COMP_WIDTH-1];
		sat = !((&hi) || (~|hi));
	end

	always_ff @(posedge clk) begin
		ovf <= sat;
		if (sat) begin
			res <= rnd[SUM_W-1] ? {1'b1, {(COMP_WIDTH-1){1'b0}}} : {1'b0, {(COMP_WIDTH-1){1'b1}}};
		end else begin
			res <= rnd[COMP_WIDTH-1:0];
		end
	end

endmodule

// ===== rtl/core/vtp_div.sv =====
module vtp_div
	import vtp_pkg::*;
(
	input  logic                  clk,
	input  logic [QUO_W-1:0]      num,
	input  logic [COMP_WIDTH-1:0] den,
	output logic [QUO_W-1:0]      quo
);

	logic [COMP_WIDTH-1:0] rem_sn [DIV_STEPS];
	logic [QUO_W-1:0]      num_sn [DIV_STEPS];
	logic [COMP_WIDTH-1:0] den_sn [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [COMP_WIDTH-1:0] rem_in;
		logic [QUO_W-1:0]      num_in;
		logic [COMP_WIDTH-1:0] den_in;
		logic [COMP_WIDTH:0]   trial;
		logic                  ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_sn[k-1];
			assign num_in = num_sn[k-1];
			assign den_in = den_sn[k-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_in, num_in[QUO_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_sn[k] <= ge ? COMP_WIDTH'(trial - {1'b0, den_in}) : trial[COMP_WIDTH-1:0];
			num_sn[k] <= {num_in[QUO_W-2:0], ge};
			den_sn[k] <= den_in;
		end
	end

	assign quo = num_sn[DIV_STEPS-1];

endmodule

// ===== rtl/core/vertex_transform_project.sv =====
// Transforms one homogeneous Q16.16 vertex per clock by the 4x4 matrix held in the
// eight 64-bit matrix registers, two per row (identity after reset), optionally
// dividing x, y and z by the transformed w. A new vertex may be started on every
// cycle; busy is never raised. Each result appears on the res ports for exactly one
// cycle with done high, after passing these registered stages in order: the four
// dot-product lanes (multiply, then sum and round), the one-bit-per-stage pipelined
// divider, and the output register. Results are in start order and cannot be
// held off, so the receiver must take every done cycle. Write the matrix only while
// no vertex is in flight.
module vertex_transform_project
	import vtp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [REG_W-1:0]   wr_data,
	input  logic [OUT_W-1:0]   vec_x,
	input  logic [OUT_W-1:0]   vec_y,
	input  logic [OUT_W-1:0]   vec_z,
	input  logic [OUT_W-1:0]   vec_w,
	input  logic               project_enable,
	output logic               done,
	output logic [OUT_W-1:0]   res_x,
	output logic [OUT_W-1:0]   res_y,
	output logic [OUT_W-1:0]   res_z,
	output logic [OUT_W-1:0]   res_w,
	output logic               w_was_zero,
	output logic               overflow
);

	logic [REG_W-1:0] mat_q [NUM_REGS];
	comp_t            vec [4];
	comp_t            coef [4][4];
	comp_t            lane_res [4];
	logic [3:0]       lane_ovf;
	logic             v_s1, v_s2, proj_s1, proj_s2;
	logic             accept;

	side_t            side_in;
	side_t            side_q [DIV_STEPS];
	side_t            side_out;
	logic [QUO_W-1:0] div_num [3];
	logic [COMP_WIDTH-1:0] div_den;
	logic [QUO_W-1:0] quo [3];

	comp_t            fin [4];
	logic [2:0]       fin_ovf;

	logic             done_q, wzero_q, ovf_q;
	comp_t            out_q [4];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= CFG_RESET[i];
			end
		end else if (wr_en) begin
			mat_q[wr_index] <= wr_data;
		end
	end

	assign vec[0] = vec_x[COMP_WIDTH-1:0];
	assign vec[1] = vec_y[COMP_WIDTH-1:0];
	assign vec[2] = vec_z[COMP_WIDTH-1:0];
	assign vec[3] = vec_w[COMP_WIDTH-1:0];

	for (genvar r = 0; r < 4; r++) begin : g_lane
		assign coef[r][0] = mat_q[2*r][COMP_WIDTH-1:0];
		assign coef[r][1] = mat_q[2*r][32+COMP_WIDTH-1:32];
		assign coef[r][2] = mat_q[2*r+1][COMP_WIDTH-1:0];
		assign coef[r][3] = mat_q[2*r+1][32+COMP_WIDTH-1:32];

		vtp_lane u_lane (
			.clk  (clk),
			.coef (coef[r]),
			.vec  (vec),
			.res  (lane_res[r]),
			.ovf  (lane_ovf[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		proj_s1 <= project_enable;
		proj_s2 <= proj_s1;
	end

	// split signs off before the unsigned divider
	always_comb begin
		side_in.valid  = v_s2;
		side_in.wzero  = proj_s2 && (lane_res[3] == '0);
		side_in.divide = proj_s2 && (lane_res[3] != '0);
		side_in.ovf    = |lane_ovf;
		for (int i = 0; i < 4; i++) begin
			side_in.res[i] = lane_res[i];
		end
		div_den = lane_res[3][COMP_WIDTH-1] ? COMP_WIDTH'(-lane_res[3]) : lane_res[3];
		for (int i = 0; i < 3; i++) begin
			side_in.neg[i] = lane_res[i][COMP_WIDTH-1] ^ lane_res[3][COMP_WIDTH-1];
			div_num[i] = {(lane_res[i][COMP_WIDTH-1] ? COMP_WIDTH'(-lane_res[i]) : lane_res[i]),
				{FRAC_BITS{1'b0}}};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		vtp_div u_div (
			.clk (clk),
			.num (div_num[i]),
			.den (div_den),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				side_q[k] <= '0;
			end
		end else begin
			side_q[0] <= side_in;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign side_out = side_q[DIV_STEPS-1];

	// merge: pick quotient or plain lane result, saturate the quotient
	always_comb begin
		fin[3] = side_out.res[3];
		for (int i = 0; i < 3; i++) begin
			fin_ovf[i] = 1'b0;
			fin[i]     = side_out.res[i];
			if (side_out.divide) begin
				if (side_out.neg[i]) begin
					fin_ovf[i] = (|quo[i][QUO_W-1:COMP_WIDTH-1]) &&
						(quo[i] != (QUO_W'(1) << (COMP_WIDTH-1)));
					fin[i] = fin_ovf[i] ? {1'b1, {(COMP_WIDTH-1){1'b0}}} :
						COMP_WIDTH'(-quo[i]);
				end else begin
					fin_ovf[i] = |quo[i][QUO_W-1:COMP_WIDTH-1];
					fin[i] = fin_ovf[i] ? {1'b0, {(COMP_WIDTH-1){1'b1}}} :
						quo[i][COMP_WIDTH-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		wzero_q <= side_out.wzero;
		ovf_q   <= side_out.ovf || (|fin_ovf);
		for (int i = 0; i < 4; i++) begin
			out_q[i] <= fin[i];
		end
	end

	assign done       = done_q;
	assign res_x      = OUT_W'(out_q[0]);
	assign res_y      = OUT_W'(out_q[1]);
	assign res_z      = OUT_W'(out_q[2]);
	assign res_w      = OUT_W'(out_q[3]);
	assign w_was_zero = wzero_q;
	assign overflow   = ovf_q;

	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1) else $error("accepted vertex lost before lanes");

	a_lanes_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> side_q[0].valid) else $error("lane result not handed to divider");

	a_div_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		side_out.valid |-> !(side_out.divide && side_out.wzero))
		else $error("divide and zero w both set");

	a_wzero_res: assert property (@(posedge clk) disable iff (!arst_n)
		(done && w_was_zero) |-> (out_q[3] == '0)) else $error("w flagged zero but nonzero");

endmodule
